@@ rtl/core/kea_pkg.sv @@
// Package for key_event_autorepeat: word types, key table, register indexes and constants.
package kea_pkg;

    localparam int TABLE_SIZE    = 21;
    localparam int TABLE_ENTRIES = 21;
    localparam int COUNT_WIDTH   = 16;
    localparam int ACTIVE_ENTRIES = (TABLE_ENTRIES < TABLE_SIZE) ? TABLE_ENTRIES : TABLE_SIZE;

    localparam int KEY_W   = 5;
    localparam int DELAY_W = 16;
    localparam int PULSE_W = 16;

    // config register indexes
    localparam logic [1:0] CFG_REMOTE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_FIRST_DELAY   = 2'd1;
    localparam logic [1:0] CFG_NEXT_DELAY    = 2'd2;

    localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd500;
    localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 16'd175;

    localparam logic [KEY_W-1:0] KEY_NONE = '0;

    typedef struct packed {
        logic [1:0]  scan_group0;
        logic [31:0] scan_group1;
        logic        usb_line;
        logic [31:0] now_ms;
        logic        cancel_repeat;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0]   pressed_key;
        logic [KEY_W-1:0]   clicked_key;
        logic [KEY_W-1:0]   repeat_key;
        logic               remote_level;
        logic [PULSE_W-1:0] remote_pulse;
    } t_out_word;

    // key table: group select (0 shutter, 1 main), key code, mask
    localparam logic KEY_GRP [TABLE_SIZE] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

    localparam logic [KEY_W-1:0] KEY_CODE [TABLE_SIZE] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
    };

    localparam logic [31:0] KEY_MASK [TABLE_SIZE] = '{
        32'h0002_0000, 32'h0008_0000, 32'h0001_0000, 32'h0004_0000, 32'h0010_0000,
        32'h0000_0003, 32'h0000_0001, 32'h1000_0000, 32'h1800_0000, 32'h0100_0000,
        32'h0500_0000, 32'h0020_0000, 32'h0000_2000, 32'h0000_4000, 32'h0040_0000,
        32'h0000_1000, 32'h0000_0008, 32'h0000_0010, 32'h0000_0020, 32'h4000_0000,
        32'h0200_0000
    };

    // entry is the first one carrying its code (used for the held-key test)
    localparam logic KEY_FIRST [TABLE_SIZE] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

endpackage

@@ rtl/core/key_event_autorepeat.sv @@
// Top level of key_event_autorepeat: scan decode, click detect, autorepeat, remote pulse count.
// An accepted input word passes through the input register and then the result register.
// Throughput: one word per cycle while i_out_ready is high; the key table compare and the 32-bit
// elapsed-time compare sit in one path between the input register and the result register.
// Reset (i_rst_n low, synchronous): valids clear, key/repeat/remote state clears,
// delays return to 500 and 175 ms, remote measurement disabled.
module key_event_autorepeat
    import kea_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // scan word in
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    // result word out
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word,
    // config writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [DELAY_W-1:0] i_cfg_data
);

    // ---------------- config registers ----------------
    logic               r_remote_enable;
    logic [DELAY_W-1:0] r_first_delay;
    logic [DELAY_W-1:0] r_next_delay;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_enable <= 1'b0;
            r_first_delay   <= FIRST_DELAY_RST;
            r_next_delay    <= NEXT_DELAY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REMOTE_ENABLE: r_remote_enable <= i_cfg_data[0];
                CFG_FIRST_DELAY:   r_first_delay   <= i_cfg_data;
                CFG_NEXT_DELAY:    r_next_delay    <= i_cfg_data;
                default: ;         // unused index, write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Stage 1 holds the accepted scan word; it moves into the result register
    // (and commits its state update) whenever that register is free or draining.
    logic     r_s1_valid;
    t_in_word r_s1_word;
    logic     r_out_valid;
    t_out_word r_out_word;
    logic     s1_go;

    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    // ---------------- persistent state ----------------
    logic [1:0]             r_prev_g0;
    logic [31:0]            r_prev_g1;
    logic [KEY_W-1:0]       r_tracked;
    logic [31:0]            r_last_time;
    logic                   r_repeating;
    logic [COUNT_WIDTH-1:0] r_remote_count;
    logic                   r_remote_level;

    logic [KEY_W-1:0]       n_tracked;
    logic [31:0]            n_last_time;
    logic                   n_repeating;
    logic [COUNT_WIDTH-1:0] n_remote_count;
    logic                   n_remote_level;
    t_out_word              n_out_word;

    // ---------------- table decode ----------------
    logic [TABLE_SIZE-1:0] cur_hit;   // all mask bits low now
    logic [TABLE_SIZE-1:0] prv_off;   // some mask bit was high last sample
    logic [KEY_W-1:0]      pressed;
    logic [KEY_W-1:0]      clicked;
    logic                  tracked_down;
    logic [KEY_W-1:0]      tracked_c;

    always_comb begin
        cur_hit = '0;
        prv_off = '0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (KEY_GRP[i]) begin
                cur_hit[i] = ((r_s1_word.scan_group1 & KEY_MASK[i]) == 32'd0);
                prv_off[i] = ((r_prev_g1 & KEY_MASK[i]) != 32'd0);
            end else begin
                cur_hit[i] = ((r_s1_word.scan_group0 & KEY_MASK[i][1:0]) == 2'd0);
                prv_off[i] = ((r_prev_g0 & KEY_MASK[i][1:0]) != 2'd0);
            end
        end
    end

    // first hit in table order: scan from the back, earlier entries override
    always_comb begin
        pressed = KEY_NONE;
        clicked = KEY_NONE;
        for (int i = ACTIVE_ENTRIES - 1; i >= 0; i--) begin
            if (cur_hit[i]) begin
                pressed = KEY_CODE[i];
                if (prv_off[i]) begin
                    clicked = KEY_CODE[i];
                end
            end
        end
    end

    // cancel drops the tracked key ahead of this sample
    assign tracked_c = r_s1_word.cancel_repeat ? KEY_NONE : r_tracked;

    // held test uses only the first active entry of the tracked code
    always_comb begin
        tracked_down = 1'b0;
        for (int i = 0; i < ACTIVE_ENTRIES; i++) begin
            if (KEY_FIRST[i] && (KEY_CODE[i] == tracked_c) && cur_hit[i]) begin
                tracked_down = 1'b1;
            end
        end
    end

    // ---------------- autorepeat ----------------
    logic [31:0]      elapsed;
    logic [31:0]      delay_ext;
    logic             delay_over;
    logic [KEY_W-1:0] repeat_key;

    assign elapsed    = r_s1_word.now_ms - r_last_time;
    assign delay_ext  = {16'd0, (r_repeating ? r_next_delay : r_first_delay)};
    // wrapping time: a negative difference never counts as elapsed
    assign delay_over = !elapsed[31] && (elapsed > delay_ext);

    always_comb begin
        n_tracked   = tracked_c;
        n_last_time = r_last_time;
        n_repeating = r_repeating;
        repeat_key  = KEY_NONE;
        if (clicked != KEY_NONE) begin
            n_tracked   = clicked;
            n_repeating = 1'b0;
            n_last_time = r_s1_word.now_ms;
            repeat_key  = clicked;
        end else if ((tracked_c != KEY_NONE) && tracked_down) begin
            if (delay_over) begin
                n_repeating = 1'b1;
                n_last_time = r_s1_word.now_ms;
                repeat_key  = tracked_c;
            end
        end else begin
            n_tracked = KEY_NONE;
        end
    end

    // ---------------- remote pulse length ----------------
    logic [31:0]        count_ext;
    logic [PULSE_W-1:0] pulse;

    assign count_ext = 32'(r_remote_count);

    always_comb begin
        n_remote_count = r_remote_count;
        n_remote_level = r_remote_level;
        pulse          = '0;
        if (r_remote_enable) begin
            n_remote_level = r_s1_word.usb_line;
            if (r_s1_word.usb_line) begin
                if (r_remote_count != '1) begin   // saturate at all ones
                    n_remote_count = r_remote_count + 1'b1;
                end
            end else if (r_remote_count != '0) begin
                pulse = (count_ext > 32'h0000_FFFF) ? '1 : count_ext[PULSE_W-1:0];
                n_remote_count = '0;
            end
        end
    end

    always_comb begin
        n_out_word.pressed_key  = pressed;
        n_out_word.clicked_key  = clicked;
        n_out_word.repeat_key   = repeat_key;
        n_out_word.remote_level = n_remote_level;
        n_out_word.remote_pulse = pulse;
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_g0      <= '0;
            r_prev_g1      <= '0;
            r_tracked      <= KEY_NONE;
            r_last_time    <= '0;
            r_repeating    <= 1'b0;
            r_remote_count <= '0;
            r_remote_level <= 1'b0;
        end else if (s1_go) begin
            r_prev_g0      <= r_s1_word.scan_group0;
            r_prev_g1      <= r_s1_word.scan_group1;
            r_tracked      <= n_tracked;
            r_last_time    <= n_last_time;
            r_repeating    <= n_repeating;
            r_remote_count <= n_remote_count;
            r_remote_level <= n_remote_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------- assertions ----------------
    // a click is always reported as the event key
    a_click_is_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.clicked_key != KEY_NONE))
        |-> (r_out_word.repeat_key == r_out_word.clicked_key))
        else $error("click not reported as event key");

    // any event needs some key down in the same sample
    a_event_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.repeat_key != KEY_NONE))
        |-> (r_out_word.pressed_key != KEY_NONE))
        else $error("event key with nothing pressed");

    // no pulse is measured while the remote is disabled
    a_no_pulse_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !r_remote_enable) |=> (r_out_word.remote_pulse == '0))
        else $error("remote pulse while disabled");

    // a stalled stage-1 word is not dropped
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("stage-1 word lost under stall");

endmodule

@@ verif/tb_key_event_autorepeat.sv @@
// Testbench for key_event_autorepeat: scoreboard check of scan decode, autorepeat and remote pulses.
module tb_key_event_autorepeat;
    import kea_pkg::*;

    // ------------------------------------------------------------------
    // Local constants
    // ------------------------------------------------------------------
    localparam int PIPE_LAT = 2;           // input reg + result reg
    localparam int N_TABLE  = 21;
    localparam int N_ACTIVE = (TABLE_ENTRIES < N_TABLE) ? TABLE_ENTRIES : N_TABLE;
    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam logic [1:0]  REL_G0 = 2'b11;          // nothing held (active low)
    localparam logic [31:0] REL_G1 = 32'hFFFF_FFFF;

    // Key table kept independently of the RTL: group (1 = main word), code, mask
    localparam bit KT_MAIN [N_TABLE] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };
    localparam logic [4:0] KT_CODE [N_TABLE] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
    };
    localparam logic [31:0] KT_MASK [N_TABLE] = '{
        32'h0002_0000, 32'h0008_0000, 32'h0001_0000, 32'h0004_0000, 32'h0010_0000,
        32'h0000_0003, 32'h0000_0001, 32'h1000_0000, 32'h1800_0000, 32'h0100_0000,
        32'h0500_0000, 32'h0020_0000, 32'h0000_2000, 32'h0000_4000, 32'h0040_0000,
        32'h0000_1000, 32'h0000_0008, 32'h0000_0010, 32'h0000_0020, 32'h4000_0000,
        32'h0200_0000
    };

    // table entries the directed part refers to
    localparam int E_UP        = 0;
    localparam int E_ZIN       = 7;    // zoom in, narrow mask
    localparam int E_ZIN_WIDE  = 8;    // zoom in, second entry
    localparam int E_ZOUT_WIDE = 10;   // zoom out, second entry
    localparam int E_MACRO     = 18;
    localparam int E_VIDEO     = 19;
    localparam int E_TIMER     = 20;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               scan_valid  = 1'b0;
    t_in_word           scan_word   = '0;
    logic               event_ready = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic [1:0]         cfg_index   = '0;
    logic [DELAY_W-1:0] cfg_data    = '0;

    logic               scan_ready;
    logic               event_valid;
    t_out_word          event_word;
    logic               cfg_ready;

    key_event_autorepeat u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (scan_valid),
        .o_in_ready  (scan_ready),
        .i_in_word   (scan_word),
        .o_out_valid (event_valid),
        .i_out_ready (event_ready),
        .o_out_word  (event_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    t_in_word  scan_backlog[$];     // words waiting to be driven
    t_out_word pending_events[$];   // predicted result words, oldest first
    int        fail_count = 0;
    bit        idle_on    = 1'b1;   // enables sender gaps and receiver stalls

    // predictor copy of the configuration
    logic        mdl_remote_en = 1'b0;
    logic [15:0] mdl_first     = FIRST_DELAY_RST;
    logic [15:0] mdl_next      = NEXT_DELAY_RST;

    // predictor copy of the block state
    logic [1:0]       prev_g0     = '0;
    logic [31:0]      prev_g1     = '0;
    logic [4:0]       held_key    = '0;
    logic [31:0]      last_evt_ms = '0;
    logic             rep_active  = 1'b0;
    longint unsigned  rmt_count   = 0;
    logic             rmt_level   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] grp_bits(bit main, logic [1:0] g0, logic [31:0] g1);
        return main ? g1 : {30'b0, g0};
    endfunction

    // held-key test looks only at the first active entry carrying the code
    function automatic logic code_held(logic [4:0] code, logic [1:0] g0, logic [31:0] g1);
        logic found;
        logic down;
        found = 1'b0;
        down  = 1'b0;
        for (int i = 0; i < N_ACTIVE; i++) begin
            if (!found && KT_CODE[i] == code) begin
                found = 1'b1;
                down  = ((grp_bits(KT_MAIN[i], g0, g1) & KT_MASK[i]) == 32'd0);
            end
        end
        return down;
    endfunction

    // Advances the predictor by one scan word and returns the result word it causes.
    function automatic t_out_word next_key_event(t_in_word w);
        t_out_word   r;
        logic [31:0] cur, prv, diff, dly;
        logic [4:0]  pressed, clicked, rep;
        logic [15:0] pulse;
        pressed = '0;
        clicked = '0;
        rep     = '0;
        pulse   = '0;
        for (int i = 0; i < N_ACTIVE; i++) begin
            cur = grp_bits(KT_MAIN[i], w.scan_group0, w.scan_group1) & KT_MASK[i];
            prv = grp_bits(KT_MAIN[i], prev_g0, prev_g1) & KT_MASK[i];
            if (cur == 32'd0) begin
                if (pressed == 5'd0) pressed = KT_CODE[i];
                if (clicked == 5'd0 && prv != 32'd0) clicked = KT_CODE[i];
            end
        end

        if (w.cancel_repeat) held_key = '0;
        if (clicked != 5'd0) begin
            held_key    = clicked;
            rep_active  = 1'b0;
            last_evt_ms = w.now_ms;
            rep         = clicked;
        end else if (held_key != 5'd0 && code_held(held_key, w.scan_group0, w.scan_group1)) begin
            // wrapping difference; bit 31 set means "in the past", never a repeat
            diff = w.now_ms - last_evt_ms;
            dly  = rep_active ? {16'd0, mdl_next} : {16'd0, mdl_first};
            if (!diff[31] && diff > dly) begin
                rep_active  = 1'b1;
                last_evt_ms = w.now_ms;
                rep         = held_key;
            end
        end else begin
            held_key = '0;
        end

        // remote pulse length, counter saturates; disabled means frozen
        if (mdl_remote_en) begin
            rmt_level = w.usb_line;
            if (w.usb_line) begin
                if (rmt_count < CNT_MAX) rmt_count++;
            end else if (rmt_count != 0) begin
                pulse     = (rmt_count > 64'd65535) ? 16'hFFFF : rmt_count[15:0];
                rmt_count = 0;
            end
        end

        prev_g0 = w.scan_group0;
        prev_g1 = w.scan_group1;

        r.pressed_key  = pressed;
        r.clicked_key  = clicked;
        r.repeat_key   = rep;
        r.remote_level = rmt_level;
        r.remote_pulse = pulse;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds scan words from the backlog in bursts with gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : scan_drv
        logic     nv;
        t_in_word nw;
        if (!i_rst_n) begin
            scan_valid <= 1'b0;
        end else begin
            nv = scan_valid;
            nw = scan_word;
            if (scan_valid && scan_ready) begin
                pending_events.push_back(next_key_event(scan_word));
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0 && idle_on) begin
                    gap_left--;
                end else if (scan_backlog.size() > 0) begin
                    nw = scan_backlog.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (idle_on) begin
                        // new burst; mostly short gaps, now and then a long one
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                                 : $urandom_range(1, 3);
                    end else begin
                        gap_left = 0;
                    end
                end
            end
            scan_valid <= nv;
            scan_word  <= nw;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result words against the predicted ones
    // ------------------------------------------------------------------
    logic [7:0] stall_tick = '0;
    int         stall_mode = 0;

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : event_mon
        t_out_word want;
        logic      rdy;
        if (!i_rst_n) begin
            event_ready <= 1'b0;
        end else begin
            if (event_valid && event_ready) begin
                if (pending_events.size() == 0) begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("pressed_key",  32'(want.pressed_key),  32'(event_word.pressed_key));
                    check_field("clicked_key",  32'(want.clicked_key),  32'(event_word.clicked_key));
                    check_field("repeat_key",   32'(want.repeat_key),   32'(event_word.repeat_key));
                    check_field("remote_level", 32'(want.remote_level), 32'(event_word.remote_level));
                    check_field("remote_pulse", 32'(want.remote_pulse), 32'(event_word.remote_pulse));
                end
            end
            // stall pattern: mode picked again each time the 8-bit stall_tick wraps to zero
            stall_tick <= stall_tick + 8'd1;
            if (stall_tick == 8'd0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: rdy = 1'b1;                                   // no stalls
                1: rdy = ($urandom_range(0, 1) == 0);            // coin flip
                2: rdy = (stall_tick[1:0] == 2'b00);             // one in four
                default: rdy = (stall_tick[5:3] != 3'b101);      // long stall runs
            endcase
            event_ready <= idle_on ? rdy : 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] gen_ms      = '0;
    logic        usb_lvl     = 1'b0;
    int          usb_run     = 0;

    task automatic push_scan(logic [1:0] g0, logic [31:0] g1, logic usb, logic [31:0] now,
                             logic cancel);
        t_in_word w;
        w.scan_group0   = g0;
        w.scan_group1   = g1;
        w.usb_line      = usb;
        w.now_ms        = now;
        w.cancel_repeat = cancel;
        scan_backlog.push_back(w);
    endtask

    // remote line: runs of random length, now and then a long one
    function automatic logic next_usb();
        if (usb_run == 0) begin
            usb_lvl = ~usb_lvl;
            usb_run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
        end else begin
            usb_run--;
        end
        return usb_lvl;
    endfunction

    function automatic logic rnd_cancel();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // time steps cluster around the active delays so the strict compare is hit
    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2, 3: return $urandom_range(2, 60);
            4: return {16'd0, mdl_first};
            5: return {16'd0, mdl_first} + 32'd1;
            6: return {16'd0, mdl_next};
            7: return {16'd0, mdl_next} + 32'd1;
            8: return $urandom_range(100, 70000);
            default: return $urandom;
        endcase
    endfunction

    // clears the mask bits of one random table entry in the scan pair
    task automatic press_any(inout logic [1:0] g0, inout logic [31:0] g1);
        int idx;
        idx = $urandom_range(0, N_TABLE - 1);
        if (KT_MAIN[idx]) g1 = g1 & ~KT_MASK[idx];
        else              g0 = g0 & ~KT_MASK[idx][1:0];
    endtask

    task automatic step_push(logic [1:0] g0, logic [31:0] g1);
        gen_ms = gen_ms + pick_step();
        push_scan(g0, g1, next_usb(), gen_ms, rnd_cancel());
    endtask

    task automatic gen_phase(int n);
        int          done;
        int          hold;
        logic [1:0]  g0;
        logic [31:0] g1;
        done = 0;
        while (done < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    // release, press one to three keys, hold, release
                    repeat ($urandom_range(1, 2)) step_push(REL_G0, REL_G1);
                    g0 = REL_G0;
                    g1 = REL_G1;
                    press_any(g0, g1);
                    if ($urandom_range(0, 3) == 0) press_any(g0, g1);
                    if ($urandom_range(0, 7) == 0) press_any(g0, g1);
                    step_push(g0, g1);
                    hold = $urandom_range(1, 10);
                    done += hold + 3;
                    repeat (hold) begin
                        case ($urandom_range(0, 5))
                            0: press_any(g0, g1);
                            1: g1 = g1 | ($urandom & $urandom);
                            default: ;
                        endcase
                        step_push(g0, g1);
                    end
                    step_push(REL_G0, REL_G1);
                end
                7: begin
                    // noise, fully random word
                    push_scan(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                              $urandom, 1'($urandom_range(0, 1)));
                    done++;
                end
                8: begin
                    // broken: tap, then press again with time running backwards
                    g0 = REL_G0;
                    g1 = REL_G1;
                    press_any(g0, g1);
                    step_push(g0, g1);
                    step_push(REL_G0, REL_G1);
                    gen_ms = gen_ms - $urandom_range(1, 1000);
                    push_scan(g0, g1, next_usb(), gen_ms, rnd_cancel());
                    step_push(g0, g1);
                    done += 4;
                end
                default: begin
                    // clock jumps, often right below the wrap point
                    gen_ms = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000)
                                                         : $urandom;
                    step_push(2'($urandom_range(0, 3)), ~($urandom & $urandom));
                    done++;
                end
            endcase
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [DELAY_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_REMOTE_ENABLE: mdl_remote_en = data[0];
            CFG_FIRST_DELAY:   mdl_first     = data;
            CFG_NEXT_DELAY:    mdl_next      = data;
            default: ;
        endcase
    endtask

    // block is idle once every word is out; then allow the pipe to settle
    task automatic wait_idle();
        while (scan_backlog.size() != 0 || scan_valid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed keys with reset delays (500 / 175) and remote disabled
        push_scan(2'b00, 32'h0, 1'b0, 32'd0, 1'b0);           // all down, no click after reset
        push_scan(REL_G0, REL_G1, 1'b0, 32'd10, 1'b0);
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1000, 1'b0);   // click
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1500, 1'b0);   // elapsed == first delay
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1501, 1'b0);   // first repeat
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1676, 1'b0);   // elapsed == next delay
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1677, 1'b0);   // next repeat
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1600, 1'b0);   // negative elapsed
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd1677 + 32'h8000_0000, 1'b0);
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd5000, 1'b1);   // cancel while held
        push_scan(REL_G0, ~KT_MASK[E_UP], 1'b0, 32'd6000, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b0, 32'hFFFF_FF00, 1'b0);
        push_scan(REL_G0, ~KT_MASK[E_ZIN_WIDE], 1'b0, 32'hFFFF_FF00, 1'b0);
        // narrow zoom mask alone still holds the key; repeat across the wrap
        push_scan(REL_G0, ~KT_MASK[E_ZIN], 1'b0, 32'h0000_0100, 1'b0);
        push_scan(2'b10, REL_G1, 1'b0, 32'h0000_0200, 1'b0);      // half press
        push_scan(2'b00, REL_G1, 1'b0, 32'h0000_0300, 1'b0);      // full press
        push_scan(REL_G0, ~KT_MASK[E_ZOUT_WIDE], 1'b0, 32'h0000_0400, 1'b0);
        // only the wide zoom bit down: no entry fully matched
        push_scan(REL_G0, ~(KT_MASK[E_ZIN_WIDE] & ~KT_MASK[E_ZIN]), 1'b0, 32'h0000_0500, 1'b0);
        push_scan(REL_G0, ~(KT_MASK[E_TIMER] | KT_MASK[E_MACRO] | KT_MASK[E_UP]), 1'b0,
                  32'h0000_0600, 1'b0);                           // several keys, table order
        push_scan(REL_G0, ~KT_MASK[E_VIDEO], 1'b0, 32'h0000_0700, 1'b1);  // cancel and click
        push_scan(REL_G0, REL_G1, 1'b0, 32'h0000_0800, 1'b0);
        wait_idle();

        // Directed remote pulses; enable written with upper bits set
        cfg_write(CFG_REMOTE_ENABLE, 16'hFFFF);
        cfg_write(CFG_FIRST_DELAY, FIRST_DELAY_RST);
        cfg_write(CFG_NEXT_DELAY, NEXT_DELAY_RST);
        push_scan(REL_G0, REL_G1, 1'b1, 32'h0000_0900, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b1, 32'h0000_0901, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b1, 32'h0000_0902, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b0, 32'h0000_0903, 1'b0);     // pulse of three
        push_scan(REL_G0, REL_G1, 1'b0, 32'h0000_0904, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b1, 32'h0000_0905, 1'b0);
        push_scan(REL_G0, REL_G1, 1'b0, 32'h0000_0906, 1'b0);
        gen_ms = 32'h0000_1000;
        wait_idle();

        // Random phases across several settings
        gen_phase(220);
        wait_idle();

        cfg_write(CFG_FIRST_DELAY, 16'd0);
        cfg_write(CFG_NEXT_DELAY, 16'd0);
        gen_phase(220);
        wait_idle();

        cfg_write(CFG_REMOTE_ENABLE, 16'h0002);                   // bit 0 clear: disabled
        cfg_write(CFG_FIRST_DELAY, 16'hFFFF);
        cfg_write(CFG_NEXT_DELAY, 16'hFFFF);
        gen_phase(220);
        wait_idle();

        cfg_write(CFG_SPARE, 16'($urandom));
        cfg_write(CFG_REMOTE_ENABLE, 16'd1);
        cfg_write(CFG_FIRST_DELAY, 16'($urandom_range(1, 1000)));
        cfg_write(CFG_NEXT_DELAY, 16'($urandom_range(1, 400)));
        gen_phase(220);
        wait_idle();

        // disabled with a count possibly in flight: it must hold
        cfg_write(CFG_REMOTE_ENABLE, 16'd0);
        cfg_write(CFG_FIRST_DELAY, 16'($urandom_range(0, 65535)));
        cfg_write(CFG_NEXT_DELAY, 16'($urandom_range(0, 65535)));
        gen_phase(220);
        wait_idle();

        cfg_write(CFG_REMOTE_ENABLE, 16'd1);
        cfg_write(CFG_FIRST_DELAY, FIRST_DELAY_RST);
        cfg_write(CFG_NEXT_DELAY, NEXT_DELAY_RST);
        gen_phase(220);
        wait_idle();

        // Drain and look for stray results
        while (scan_backlog.size() != 0 || scan_valid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_key_event_autorepeat passed");
        end else begin
            $display("tb_key_event_autorepeat failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("tb_key_event_autorepeat failed");
        $finish;
    end

endmodule
